### rtl/core/las_pkg.sv
package las_pkg;

    localparam int SYM_W      = 8;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_SUBJECT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
    } t_tok;

    typedef struct packed {
        logic        [3:0] match;
        logic signed [4:0] mismatch;
        logic signed [4:0] gap;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{match: 4'd1, mismatch: -5'sd1, gap: -5'sd1};

endpackage

### rtl/core/las_in_if.sv
interface las_in_if import las_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output operation, output symbol, output last, input ready);
    modport sink   (input valid, input operation, input symbol, input last, output ready);
endinterface

### rtl/core/las_out_if.sv
interface las_out_if #(
    parameter int SCORE_BITS = 10,
    parameter int ROW_W      = 7,
    parameter int COL_W      = 13
);
    logic                  valid;
    logic                  ready;
    logic [SCORE_BITS-1:0] best_score;
    logic [ROW_W-1:0]      best_row;
    logic [COL_W-1:0]      best_col;

    modport source (output valid, output best_score, output best_row, output best_col,
                    input ready);
    modport sink   (input valid, input best_score, input best_row, input best_col,
                    output ready);
endinterface

### rtl/core/local_alignment_score.sv
// Sequencing: a subject request passes the chain of cells, registered in each cell; a
// request marked last then enters S_FIN, which loads the registered result once
// the output is free. Input is taken only when idle, so a new subject request waits until
// the last has left the chain, one row per cycle, and S_FIN. Query appends, clears
// and subject requests past the column limit stay idle, unless the latter is marked last.
// Reset: synchronous, active low; clears query length, column scores, best cell, subject
// count and output valid, and restores the default scores. No clearing pass is needed.
module local_alignment_score import las_pkg::*; #(
    parameter int MAX_QUERY   = 64,
    parameter int MAX_SUBJECT = 4096,
    parameter int SCORE_BITS  = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    las_in_if.sink                i_in,
    las_out_if.source             o_out
);

    localparam int ROW_W = $clog2(MAX_QUERY + 1);
    localparam int COL_W = $clog2(MAX_SUBJECT + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [ROW_W-1:0]      r_len, n_len;
    logic [COL_W-1:0]      r_count, n_count;
    logic                  r_last, n_last;
    logic [SCORE_BITS-1:0] r_bval, n_bval;
    logic [ROW_W-1:0]      r_brow, n_brow;
    logic [COL_W-1:0]      r_bcol, n_bcol;
    logic                  r_o_valid, n_o_valid;
    logic [SCORE_BITS-1:0] r_o_score, n_o_score;
    logic [ROW_W-1:0]      r_o_row, n_o_row;
    logic [COL_W-1:0]      r_o_col, n_o_col;
    t_cfg                  r_cfg;

    logic                  w_acc;
    logic                  w_wr;
    logic                  w_clr;
    logic [MAX_QUERY-1:0]  w_en;
    t_tok                  w_tok    [0:MAX_QUERY];
    logic [SCORE_BITS-1:0] w_diag   [0:MAX_QUERY];
    logic [SCORE_BITS-1:0] w_up     [0:MAX_QUERY];
    logic [SCORE_BITS-1:0] w_bval   [0:MAX_QUERY];
    logic [ROW_W-1:0]      w_brow   [0:MAX_QUERY];
    logic                  w_better;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;

    assign w_diag[0] = '0;
    assign w_up[0]   = '0;
    assign w_bval[0] = '0;
    assign w_brow[0] = '0;

    for (genvar g = 0; g < MAX_QUERY; g++) begin : g_cell
        assign w_en[g] = (ROW_W'(g) < r_len);

        las_cell #(
            .SCORE_BITS (SCORE_BITS),
            .ROW_W      (ROW_W),
            .ROW        (g + 1)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en[g]),
            .i_wr     (w_wr && (r_len == ROW_W'(g))),
            .i_wr_sym (i_in.symbol),
            .i_clr    (w_clr),
            .i_cfg    (r_cfg),
            .i_tok    (w_tok[g]),
            .i_diag   (w_diag[g]),
            .i_up     (w_up[g]),
            .i_bval   (w_bval[g]),
            .i_brow   (w_brow[g]),
            .o_tok    (w_tok[g+1]),
            .o_diag   (w_diag[g+1]),
            .o_up     (w_up[g+1]),
            .o_bval   (w_bval[g+1]),
            .o_brow   (w_brow[g+1])
        );
    end

    assign w_better = (w_bval[MAX_QUERY] > r_bval) ||
                      ((w_bval[MAX_QUERY] != '0) && (w_bval[MAX_QUERY] == r_bval) &&
                       (w_brow[MAX_QUERY] < r_brow));

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_count   = r_count;
        n_last    = r_last;
        n_bval    = r_bval;
        n_brow    = r_brow;
        n_bcol    = r_bcol;
        n_o_valid = r_o_valid;
        n_o_score = r_o_score;
        n_o_row   = r_o_row;
        n_o_col   = r_o_col;
        w_wr      = 1'b0;
        w_clr     = 1'b0;
        w_tok[0]  = '0;

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_in.operation)
                        OP_APPEND: begin
                            if (r_len < ROW_W'(MAX_QUERY)) begin
                                w_wr  = 1'b1;
                                n_len = r_len + ROW_W'(1);
                            end
                        end
                        OP_CLEAR: begin
                            w_clr   = 1'b1;
                            n_len   = '0;
                            n_count = '0;
                            n_bval  = '0;
                            n_brow  = '0;
                            n_bcol  = '0;
                        end
                        OP_SUBJECT: begin
                            n_last = i_in.last;
                            if (r_count < COL_W'(MAX_SUBJECT)) begin
                                w_tok[0].valid  = 1'b1;
                                w_tok[0].symbol = i_in.symbol;
                                n_count         = r_count + COL_W'(1);
                                n_state         = S_RUN;
                            end else if (i_in.last) begin
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (w_tok[MAX_QUERY].valid) begin
                    if (w_better) begin
                        n_bval = w_bval[MAX_QUERY];
                        n_brow = w_brow[MAX_QUERY];
                        n_bcol = r_count;
                    end
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o_score = r_bval;
                    n_o_row   = r_brow;
                    n_o_col   = r_bcol;
                    w_clr     = 1'b1;
                    n_count   = '0;
                    n_bval    = '0;
                    n_brow    = '0;
                    n_bcol    = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_count   <= '0;
            r_bval    <= '0;
            r_brow    <= '0;
            r_bcol    <= '0;
            r_o_valid <= 1'b0;
            r_cfg     <= CFG_RESET;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_count   <= n_count;
            r_bval    <= n_bval;
            r_brow    <= n_brow;
            r_bcol    <= n_bcol;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MATCH:    r_cfg.match    <= i_cfg_data[3:0];
                    CFG_MISMATCH: r_cfg.mismatch <= $signed(i_cfg_data);
                    CFG_GAP:      r_cfg.gap      <= $signed(i_cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last    <= n_last;
        r_o_score <= n_o_score;
        r_o_row   <= n_o_row;
        r_o_col   <= n_o_col;
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.best_score = r_o_score;
    assign o_out.best_row   = r_o_row;
    assign o_out.best_col   = r_o_col;

endmodule

### rtl/core/las_cell.sv
module las_cell import las_pkg::*; #(
    parameter int SCORE_BITS = 10,
    parameter int ROW_W      = 7,
    parameter int ROW        = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_wr,
    input  logic [SYM_W-1:0]      i_wr_sym,
    input  logic                  i_clr,
    input  t_cfg                  i_cfg,
    input  t_tok                  i_tok,
    input  logic [SCORE_BITS-1:0] i_diag,
    input  logic [SCORE_BITS-1:0] i_up,
    input  logic [SCORE_BITS-1:0] i_bval,
    input  logic [ROW_W-1:0]      i_brow,
    output t_tok                  o_tok,
    output logic [SCORE_BITS-1:0] o_diag,
    output logic [SCORE_BITS-1:0] o_up,
    output logic [SCORE_BITS-1:0] o_bval,
    output logic [ROW_W-1:0]      o_brow
);

    localparam int AW = SCORE_BITS + 2;
    localparam logic signed [AW-1:0] SMAX = AW'((1 << SCORE_BITS) - 1);

    logic [SYM_W-1:0]      r_sym;
    logic [SCORE_BITS-1:0] r_h;
    t_tok                  r_tok;
    logic [SCORE_BITS-1:0] r_diag;
    logic [SCORE_BITS-1:0] r_up;
    logic [SCORE_BITS-1:0] r_bval;
    logic [ROW_W-1:0]      r_brow;

    logic signed [AW-1:0]  s;
    logic signed [AW-1:0]  gap_x;
    logic signed [AW-1:0]  a;
    logic signed [AW-1:0]  b;
    logic signed [AW-1:0]  c;
    logic signed [AW-1:0]  m;
    logic [SCORE_BITS-1:0] v;
    logic                  hit;
    logic                  better;

    always_comb begin
        if (r_sym == i_tok.symbol) begin
            s = $signed({{(AW-4){1'b0}}, i_cfg.match});
        end else begin
            s = $signed({{(AW-5){i_cfg.mismatch[4]}}, i_cfg.mismatch});
        end
        gap_x = $signed({{(AW-5){i_cfg.gap[4]}}, i_cfg.gap});
        a = $signed({2'b00, i_diag}) + s;
        b = $signed({2'b00, r_h}) + gap_x;
        c = $signed({2'b00, i_up}) + gap_x;
        m = '0;
        if (a > m) begin
            m = a;
        end
        if (b > m) begin
            m = b;
        end
        if (c > m) begin
            m = c;
        end
        if (m > SMAX) begin
            v = '1;
        end else begin
            v = m[SCORE_BITS-1:0];
        end
        hit    = i_en && i_tok.valid;
        better = hit && (v > i_bval);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_h   <= '0;
        end else begin
            r_tok <= i_tok;
            if (i_clr) begin
                r_h <= '0;
            end else if (hit) begin
                r_h <= v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_sym <= i_wr_sym;
        end
        r_diag <= r_h;
        r_up   <= hit ? v : i_up;
        r_bval <= better ? v : i_bval;
        r_brow <= better ? ROW_W'(ROW) : i_brow;
    end

    assign o_tok  = r_tok;
    assign o_diag = r_diag;
    assign o_up   = r_up;
    assign o_bval = r_bval;
    assign o_brow = r_brow;

endmodule
